// File: hdl/i2a_pkg.sv
// Package with shared constants, the controller state type and the digit encoder.
package i2a_pkg;

    localparam int WORD_W     = 32;
    localparam int DIGIT_W    = 4;
    localparam int DEC_DIGITS = 10;
    localparam int HEX_DIGITS = WORD_W / DIGIT_W;
    localparam int BCD_W      = DEC_DIGITS * DIGIT_W;
    localparam int CHAR_W     = 8;
    localparam int BIT_CNT_W  = $clog2(WORD_W);
    localparam int REM_W      = $clog2(DEC_DIGITS + 1);

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_A     = 8'h41;

    localparam logic MODE_DEC = 1'b0;
    localparam logic MODE_HEX = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < 4'd10)
            c = CHAR_ZERO + {4'd0, d};
        else
            c = CHAR_A + {4'd0, d} - 8'd10;
        return c;
    endfunction

endpackage

// File: hdl/integer_to_ascii_emitter_core.sv
// Top level: converts a 32-bit value to decimal or hex ASCII, one character per beat.
//
// Usage: drive number_bits and action and raise start while busy is low; the value is
// taken at that clock edge and busy rises on the next cycle. Characters leave on
// ascii_char with valid high for exactly one cycle per beat, most significant first;
// last_char marks the final character of the text. The receiver cannot stall, so it
// must take every beat on the cycle it appears.
// Decimal mode (action 0) reads the value as signed, prints a leading minus for
// negatives and suppresses leading zeros. It runs a bit-serial shift-and-add-3
// conversion over all 32 input bits, then walks the ten BCD digits one per cycle,
// after a slot for the minus sign when the value is negative.
// Hex mode (action 1) walks the eight nibbles one per cycle with at least two digits
// printed; other leading zeros are suppressed.
// Each character is registered and appears in the cycle after its slot (minus sign
// or a digit slot that is not a skipped leading zero); the last one appears in the
// first cycle with busy low. A new value may be started in that same cycle. Once
// the first digit is out, digits leave at one per cycle until the digit-walk
// counter runs out.
// Reset returns the controller to idle and drops valid and last_char; no other state is reset.
module integer_to_ascii_emitter_core
    import i2a_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [WORD_W-1:0] number_bits,
    input  logic              action,
    output logic              valid,
    output logic [CHAR_W-1:0] ascii_char,
    output logic              last_char
);

    state_t               state_reg, state_next;
    logic [WORD_W-1:0]    bin_reg, bin_next;
    logic [BCD_W-1:0]     digit_reg, digit_next;
    logic [BIT_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic                 minus_reg, minus_next;
    logic                 started_reg, started_next;
    logic                 hex_reg, hex_next;
    logic                 valid_reg, valid_next;
    logic [CHAR_W-1:0]    char_reg, char_next;
    logic                 last_reg, last_next;

    logic [BCD_W-1:0]     bcd_adj;
    logic [DIGIT_W-1:0]   top_digit;
    logic [REM_W-1:0]     min_digits;
    logic                 skip_zero;

    always_comb
    begin
        for (int i = 0; i < DEC_DIGITS; i++)
        begin
            if (digit_reg[i*DIGIT_W +: DIGIT_W] >= 4'd5)
                bcd_adj[i*DIGIT_W +: DIGIT_W] = digit_reg[i*DIGIT_W +: DIGIT_W] + 4'd3;
            else
                bcd_adj[i*DIGIT_W +: DIGIT_W] = digit_reg[i*DIGIT_W +: DIGIT_W];
        end
    end

    assign top_digit  = digit_reg[BCD_W-1 -: DIGIT_W];
    assign min_digits = hex_reg ? REM_W'(2) : REM_W'(1);
    assign skip_zero  = !started_reg && (top_digit == '0) && (rem_reg > min_digits);

    always_comb
    begin
        state_next   = state_reg;
        bin_next     = bin_reg;
        digit_next   = digit_reg;
        bit_cnt_next = bit_cnt_reg;
        rem_next     = rem_reg;
        minus_next   = minus_reg;
        started_next = started_reg;
        hex_next     = hex_reg;
        valid_next   = 1'b0;
        char_next    = char_reg;
        last_next    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    started_next = 1'b0;
                    hex_next     = action;
                    if (action == MODE_HEX)
                    begin
                        digit_next = {number_bits, {(BCD_W-WORD_W){1'b0}}};
                        rem_next   = REM_W'(HEX_DIGITS);
                        minus_next = 1'b0;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        minus_next   = number_bits[WORD_W-1];
                        bin_next     = number_bits[WORD_W-1] ? (~number_bits + 1'b1)
                                                             : number_bits;
                        digit_next   = '0;
                        bit_cnt_next = BIT_CNT_W'(WORD_W - 1);
                        state_next   = ST_CONV;
                    end
                end
            end
            ST_CONV:
            begin
                digit_next   = {bcd_adj[BCD_W-2:0], bin_reg[WORD_W-1]};
                bin_next     = {bin_reg[WORD_W-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == '0)
                begin
                    rem_next   = REM_W'(DEC_DIGITS);
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (minus_reg)
                begin
                    minus_next = 1'b0;
                    valid_next = 1'b1;
                    char_next  = CHAR_MINUS;
                end
                else
                begin
                    digit_next = {digit_reg[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                    rem_next   = rem_reg - 1'b1;
                    if (!skip_zero)
                    begin
                        started_next = 1'b1;
                        valid_next   = 1'b1;
                        char_next    = digit_to_ascii(top_digit);
                        last_next    = (rem_reg == REM_W'(1));
                    end
                    if (rem_reg == REM_W'(1))
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg     <= bin_next;
        digit_reg   <= digit_next;
        bit_cnt_reg <= bit_cnt_next;
        rem_reg     <= rem_next;
        minus_reg   <= minus_next;
        started_reg <= started_next;
        hex_reg     <= hex_next;
        char_reg    <= char_next;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign valid      = valid_reg;
    assign ascii_char = char_reg;
    assign last_char  = last_reg;

    a_valid_follows_work: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> $past(busy))
        else $error("Character beat without a conversion in progress.");

    a_last_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        last_char |-> valid)
        else $error("Last flag raised outside a beat.");

    a_start_takes: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("Accepted value did not start a conversion.");

    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && ascii_char == CHAR_MINUS) |-> !last_char)
        else $error("Minus sign marked as the final character.");

    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        last_char |-> !busy)
        else $error("Controller still busy after the final character.");

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the integer to ASCII emitter, with a scoreboard that predicts the text.
module tb_top
    import i2a_pkg::*;
();

    localparam int RADIX_DEC    = 10;
    localparam int RADIX_HEX    = 16;
    localparam int DRAIN_CYCLES = 60;
    localparam int PHASE_ITEMS  = 40;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              fin;
    } char_beat_t;

    class text_scoreboard;
        char_beat_t expected_chars[$];
        int         errors = 0;

        function void note_value(logic [WORD_W-1:0] v, logic mode);
            logic [WORD_W-1:0] mag;
            logic [CHAR_W-1:0] digits[$];
            logic [3:0]        nib;
            char_beat_t        b;
            mag = v;
            if (mode == MODE_HEX)
            begin
                do
                begin
                    nib = mag[3:0];
                    if (nib < RADIX_DEC)
                        digits.push_front(CHAR_ZERO + CHAR_W'(nib));
                    else
                        digits.push_front(CHAR_A + CHAR_W'(nib) - CHAR_W'(RADIX_DEC));
                    mag = mag / RADIX_HEX;
                end
                while (mag != 0);
                if (digits.size() < 2)
                    digits.push_front(CHAR_ZERO);
            end
            else
            begin
                if (v[WORD_W-1])
                    mag = -v;
                do
                begin
                    digits.push_front(CHAR_ZERO + CHAR_W'(mag % RADIX_DEC));
                    mag = mag / RADIX_DEC;
                end
                while (mag != 0);
                if (v[WORD_W-1])
                    digits.push_front(CHAR_MINUS);
            end
            foreach (digits[k])
            begin
                b.ch  = digits[k];
                b.fin = (k == digits.size() - 1);
                expected_chars.push_back(b);
            end
        endfunction

        function void check_beat(logic [CHAR_W-1:0] ch, logic fin);
            char_beat_t want;
            if (expected_chars.size() == 0)
            begin
                $display("%0t: unexpected beat: ascii_char %h last_char %b", $time, ch, fin);
                errors++;
                return;
            end
            want = expected_chars.pop_front();
            if (ch !== want.ch)
            begin
                $display("%0t: ascii_char expected %h actual %h", $time, want.ch, ch);
                errors++;
            end
            if (fin !== want.fin)
            begin
                $display("%0t: last_char expected %b actual %b", $time, want.fin, fin);
                errors++;
            end
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [WORD_W-1:0] number_bits = '0;
    logic              action = MODE_DEC;
    logic              valid;
    logic [CHAR_W-1:0] ascii_char;
    logic              last_char;

    int pct_list[4] = '{0, 83, 13, 0};

    text_scoreboard sb = new();

    integer_to_ascii_emitter_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .number_bits (number_bits),
        .action      (action),
        .valid       (valid),
        .ascii_char  (ascii_char),
        .last_char   (last_char)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && valid)
            sb.check_beat(ascii_char, last_char);
    end

    task automatic send_value(input logic [WORD_W-1:0] v, input logic mode);
        logic taken;
        @(negedge clk);
        start       <= 1'b1;
        number_bits <= v;
        action      <= mode;
        taken = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            taken = !busy;
        end
        sb.note_value(v, mode);
    endtask

    task automatic sender_gap(input int pct);
        int n;
        n = 0;
        while ($urandom_range(99) < pct && n < 60)
            n++;
        if (n > 0)
        begin
            @(negedge clk);
            start       <= 1'b0;
            number_bits <= $urandom();
            action      <= 1'($urandom_range(1));
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic drain_text();
        @(negedge clk);
        start <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic logic [WORD_W-1:0] pick_value();
        logic [WORD_W-1:0] v;
        case ($urandom_range(4))
            0: v = $urandom();
            1: v = $urandom() >> $urandom_range(WORD_W - 1);
            2: v = -($urandom() >> $urandom_range(WORD_W - 1));
            3: v = $urandom_range(20);
            default: v = {1'b1, {(WORD_W - 1){1'b0}}} | ($urandom() >> $urandom_range(31, 1));
        endcase
        return v;
    endfunction

    initial
    begin
        int pct;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        send_value(32'd0, MODE_DEC);
        send_value(32'd1, MODE_DEC);
        send_value(32'd9, MODE_DEC);
        send_value(32'd10, MODE_DEC);
        send_value(32'hFFFF_FFFF, MODE_DEC);
        send_value(32'h7FFF_FFFF, MODE_DEC);
        send_value(32'h8000_0000, MODE_DEC);
        send_value(32'h8000_0001, MODE_DEC);
        send_value(32'd1000000000, MODE_DEC);
        send_value(-32'd1000000000, MODE_DEC);
        send_value(32'd123456789, MODE_DEC);
        send_value(-32'd10, MODE_DEC);
        send_value(32'd0, MODE_HEX);
        send_value(32'd1, MODE_HEX);
        send_value(32'hF, MODE_HEX);
        send_value(32'h10, MODE_HEX);
        send_value(32'hFF, MODE_HEX);
        send_value(32'hFFFF_FFFF, MODE_HEX);
        send_value(32'h8000_0000, MODE_HEX);
        send_value(32'h0ABC_DEF0, MODE_HEX);
        send_value(32'h1234_5678, MODE_HEX);
        send_value(32'h7FFF_FFFF, MODE_HEX);
        drain_text();

        foreach (pct_list[p])
        begin
            pct = pct_list[p];
            repeat (PHASE_ITEMS)
            begin
                send_value(pick_value(), 1'($urandom_range(1)));
                sender_gap(pct);
            end
            drain_text();
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
